// File: src/htd_pkg.sv
// Shared constants and types for the Huffman tree load and decode block.
// No dependencies; imported by the output buffer and the top level.
package htd_pkg;

  localparam int NODE_SLOTS  = 512;
  localparam int STACK_SLOTS = 256;

  localparam int NODE_AW  = $clog2(NODE_SLOTS);
  localparam int STACK_AW = $clog2(STACK_SLOTS);
  localparam int LEVEL_W  = $clog2(STACK_SLOTS + 1);
  localparam int USED_W   = $clog2(NODE_SLOTS + 1);
  // a child field holds either a node index or a symbol byte
  localparam int CHILD_W  = (NODE_AW > 8) ? NODE_AW : 8;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_EARLY_END = 2'd1,
    ERR_TREE      = 2'd2
  } err_t;

  typedef struct packed {
    logic               is_leaf;
    logic [CHILD_W-1:0] val;
  } child_t;

  // internal node as held in the node RAM
  typedef struct packed {
    child_t left;
    child_t right;
  } node_t;

  // internal node waiting for its children
  typedef struct packed {
    logic [NODE_AW-1:0] idx;
    logic               lset;
    child_t             left;
  } frame_t;

  typedef struct packed {
    logic [7:0]  symbol;
    logic [31:0] repeat_res;
    logic        last;
    err_t        error;
  } result_t;

endpackage

// File: src/htd_ifs.sv
// Valid/ready channel interfaces: code bits in, decoded results out.
// Depends on nothing; used by the top level and the output buffer.
interface htd_code_if;
  logic valid;
  logic ready;
  logic code_bit;
  logic stream_end;

  modport source (output valid, code_bit, stream_end, input ready);
  modport sink   (input valid, code_bit, stream_end, output ready);
endinterface

interface htd_sym_if;
  logic        valid;
  logic        ready;
  logic [7:0]  symbol;
  logic [31:0] repeat_res;
  logic        last;
  logic [1:0]  error;

  modport source (output valid, symbol, repeat_res, last, error, input ready);
  modport sink   (input valid, symbol, repeat_res, last, error, output ready);
endinterface

// File: src/htd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// A read of the address being written returns the new data.
module htd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/htd_out_buf.sv
// Two-entry output buffer: result register plus skid stage.
// Depends on htd_pkg and htd_sym_if.
module htd_out_buf
  import htd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  result_t          in_data,
  output logic             can_take,
  htd_sym_if.source        result
);

  logic    out_valid;
  logic    skid_valid;
  result_t out_data;
  result_t skid_data;
  logic    out_free;

  assign out_free = !out_valid || result.ready;
  assign can_take = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || in_valid;
      skid_valid <= skid_valid && in_valid;
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data  <= skid_valid ? skid_data : in_data;
      skid_data <= in_data;
    end else if (in_valid) begin
      skid_data <= in_data;
    end
  end

  assign result.valid      = out_valid;
  assign result.symbol     = out_data.symbol;
  assign result.repeat_res = out_data.repeat_res;
  assign result.last       = out_data.last;
  assign result.error      = out_data.error;

  // a waiting skid beat implies the output register is full
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while output register is empty");

endmodule

// File: src/huffman_tree_load_and_decode.sv
// Top level: Huffman tree loader (preorder bit stream) and bit-serial decoder.
// Depends on htd_pkg, htd_ifs, htd_ram, htd_out_buf.
//
//  channel  dir  handshake     beat contents
//  code     in   valid/ready   code_bit, stream_end
//  result   out  valid/ready   symbol, repeat_res, last, error
//  cfg      in   cfg_wr_en     cfg_wr_data = symbol_count
//
// One code bit per cycle, load and decode alike, while code.ready is high.
// Load: a 0 bit adds an internal node, a 1 and eight symbol bits a leaf.
// Decode: each bit moves the walk one node and issues the next node RAM read.
// Results pass a result register and a skid stage; code.ready drops only
// while both hold a beat.
// rst is synchronous; no clearing pass, the RAMs are written before read.
// After an error or the last symbol, bits are taken and dropped until reset.
module huffman_tree_load_and_decode
  import htd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  htd_code_if.sink    code,
  htd_sym_if.source   result
);

  typedef enum logic [1:0] {
    PH_LOAD,
    PH_DECODE,
    PH_DONE
  } phase_t;

  localparam logic [3:0] LEAF_LAST = 4'd8;

  phase_t             phase, phase_next;
  logic [31:0]        symbol_count;
  logic [LEVEL_W-1:0] level, level_next;
  logic [USED_W-1:0]  nodes_used, used_next;
  logic [7:0]         leaf_byte, leaf_byte_next;
  logic [3:0]         leaf_bits_seen, leaf_bits_next;
  logic [NODE_AW-1:0] walk, walk_next;
  logic [31:0]        symbols_done, done_next;
  frame_t             top, top_next;
  frame_t             below, below_next, below_eff;
  logic               below_stale, below_stale_next;

  logic               take;
  logic               can_take;
  logic [7:0]         leaf_sym;
  logic               add_leaf;
  logic               add_full;
  child_t             new_child;
  frame_t             new_frame;
  frame_t             top_set;
  child_t             step_child;
  logic [31:0]        done_inc;
  logic               done_last;

  logic               node_we;
  node_t              node_wdata;
  node_t              node_rdata;
  logic               stk_we;
  frame_t             stk_rdata;
  logic [LEVEL_W-1:0] stk_raddr_full;
  logic [LEVEL_W-1:0] stk_waddr_full;

  logic               res_valid;
  result_t            res;

  assign code.ready = can_take;
  assign take       = code.valid && can_take;

  assign below_eff = below_stale ? stk_rdata : below;
  assign leaf_sym  = {leaf_byte[6:0], code.code_bit};
  assign add_leaf  = (leaf_bits_seen == LEAF_LAST);
  assign new_child = add_leaf ? child_t'{is_leaf: 1'b1, val: CHILD_W'(leaf_sym)}
                              : child_t'{is_leaf: 1'b0,
                                         val: CHILD_W'(nodes_used[NODE_AW-1:0])};
  assign new_frame = '{idx: nodes_used[NODE_AW-1:0], lset: 1'b0, left: '0};
  assign top_set   = '{idx: top.idx, lset: 1'b1, left: new_child};
  assign add_full  = (nodes_used >= USED_W'(NODE_SLOTS)) ||
                     (!add_leaf && (level == LEVEL_W'(STACK_SLOTS)) && !top.lset);
  assign node_wdata = '{left: top.left, right: new_child};

  assign step_child = code.code_bit ? node_rdata.right : node_rdata.left;
  assign done_inc   = symbols_done + 32'd1;
  assign done_last  = (done_inc >= symbol_count) || (done_inc == '0);

  always_comb begin
    phase_next       = phase;
    level_next       = level;
    used_next        = nodes_used;
    leaf_byte_next   = leaf_byte;
    leaf_bits_next   = leaf_bits_seen;
    walk_next        = walk;
    done_next        = symbols_done;
    top_next         = top;
    below_next       = below_eff;
    below_stale_next = 1'b0;
    node_we          = 1'b0;
    stk_we           = 1'b0;
    res_valid        = 1'b0;
    res              = '{symbol: '0, repeat_res: '0, last: 1'b1, error: ERR_NONE};

    if (take) begin
      unique case (phase)
        PH_LOAD: begin
          if (code.stream_end) begin
            res_valid  = 1'b1;
            res.error  = ERR_EARLY_END;
            phase_next = PH_DONE;
          end else if (leaf_bits_seen == '0 && code.code_bit) begin
            leaf_bits_next = 4'd1;
            leaf_byte_next = '0;
          end else if (leaf_bits_seen != '0 && !add_leaf) begin
            leaf_byte_next = leaf_sym;
            leaf_bits_next = leaf_bits_seen + 4'd1;
          end else if (add_full) begin
            res_valid  = 1'b1;
            res.error  = ERR_TREE;
            phase_next = PH_DONE;
          end else begin
            used_next = nodes_used + USED_W'(1);
            if (add_leaf) begin
              leaf_bits_next = '0;
              leaf_byte_next = leaf_sym;
            end
            if (level == '0) begin
              if (add_leaf) begin
                // whole tree is one leaf
                res_valid      = 1'b1;
                res.symbol     = leaf_sym;
                res.repeat_res = symbol_count;
                phase_next     = PH_DONE;
              end else begin
                top_next   = new_frame;
                level_next = LEVEL_W'(1);
              end
            end else if (!top.lset) begin
              top_next = top_set;
              if (!add_leaf) begin
                stk_we     = 1'b1;
                below_next = top_set;
                top_next   = new_frame;
                level_next = level + LEVEL_W'(1);
              end
            end else begin
              // right child arrives: parent is complete
              node_we = 1'b1;
              if (add_leaf) begin
                top_next         = below_eff;
                level_next       = level - LEVEL_W'(1);
                below_stale_next = 1'b1;
                if (level == LEVEL_W'(1)) begin
                  if (symbol_count == '0) begin
                    res_valid  = 1'b1;
                    phase_next = PH_DONE;
                  end else begin
                    phase_next = PH_DECODE;
                    walk_next  = '0;
                    done_next  = '0;
                  end
                end
              end else begin
                top_next = new_frame;
              end
            end
          end
        end
        PH_DECODE: begin
          if (code.stream_end) begin
            res_valid  = 1'b1;
            res.error  = ERR_EARLY_END;
            phase_next = PH_DONE;
          end else if (step_child.is_leaf) begin
            walk_next      = '0;
            done_next      = done_inc;
            res_valid      = 1'b1;
            res.symbol     = step_child.val[7:0];
            res.repeat_res = 32'd1;
            res.last       = done_last;
            if (done_last) begin
              phase_next = PH_DONE;
            end
          end else begin
            walk_next = step_child.val[NODE_AW-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign stk_raddr_full = level_next - LEVEL_W'(2);
  assign stk_waddr_full = level - LEVEL_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LOAD;
      symbol_count   <= '0;
      level          <= '0;
      nodes_used     <= '0;
      leaf_bits_seen <= '0;
      walk           <= '0;
      symbols_done   <= '0;
      below_stale    <= 1'b0;
    end else begin
      phase          <= phase_next;
      level          <= level_next;
      nodes_used     <= used_next;
      leaf_bits_seen <= leaf_bits_next;
      walk           <= walk_next;
      symbols_done   <= done_next;
      below_stale    <= below_stale_next;
      if (cfg_wr_en) begin
        symbol_count <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    leaf_byte <= leaf_byte_next;
    top       <= top_next;
    below     <= below_next;
  end

  // internal nodes, addressed by node index; read at the walk position
  htd_ram #(
    .WIDTH ($bits(node_t)),
    .DEPTH (NODE_SLOTS)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (top.idx),
    .wdata (node_wdata),
    .raddr (walk_next),
    .rdata (node_rdata)
  );

  // pending parents below the top-of-stack register
  htd_ram #(
    .WIDTH ($bits(frame_t)),
    .DEPTH (STACK_SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr_full[STACK_AW-1:0]),
    .wdata (top_set),
    .raddr (stk_raddr_full[STACK_AW-1:0]),
    .rdata (stk_rdata)
  );

  htd_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_data  (res),
    .can_take (can_take),
    .result   (result)
  );

  a_decode_stack_empty: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DECODE) |-> (level == '0))
    else $error("parent stack not empty while decoding");

  a_last_ends_stream: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.last) |=> (phase == PH_DONE))
    else $error("final beat issued without leaving load/decode");

  a_decode_has_tree: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DECODE) |-> (nodes_used >= USED_W'(3)))
    else $error("decoding with fewer than three nodes");

  a_stale_after_pop: assert property (@(posedge clk) disable iff (rst)
    below_stale |-> ($past(level) == level + LEVEL_W'(1)))
    else $error("stack refill without a preceding pop");

endmodule
